// ===== design/mvd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvd_pkg
// Shared types, constants and helper functions of the MAVLink v2 frame
// decoder: payload words, frame summary, CRC step and message table.
// ----------------------------------------------------------------------------
package mvd_pkg;

    // Payload capture store
    localparam int CAPTURE_BYTES = 32;
    localparam int CAP_AW        = $clog2(CAPTURE_BYTES);

    // Framing constants
    localparam logic [7:0]  START_BYTE    = 8'hFD;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [8:0]  INDEX_MAX     = 9'd511;
    localparam logic [8:0]  PAYLOAD_START = 9'd10;

    // Result status codes, lowest code wins
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_START = 3'd1;
    localparam logic [2:0] ST_BAD_TAGS  = 3'd2;
    localparam logic [2:0] ST_LENGTH    = 3'd3;
    localparam logic [2:0] ST_ZERO_ID   = 3'd4;
    localparam logic [2:0] ST_UNKNOWN   = 3'd5;
    localparam logic [2:0] ST_CRC       = 3'd6;
    localparam logic [2:0] ST_SHORT     = 3'd7;

    // Decoded message kinds
    localparam logic [2:0] KIND_HEARTBEAT  = 3'd0;
    localparam logic [2:0] KIND_SYS_STATUS = 3'd1;
    localparam logic [2:0] KIND_ATTITUDE   = 3'd2;
    localparam logic [2:0] KIND_GLOBAL_POS = 3'd3;
    localparam logic [2:0] KIND_TIMESYNC   = 3'd4;

    // Message ids
    localparam logic [23:0] MSG_HEARTBEAT  = 24'd0;
    localparam logic [23:0] MSG_SYS_STATUS = 24'd1;
    localparam logic [23:0] MSG_ATTITUDE   = 24'd30;
    localparam logic [23:0] MSG_GLOBAL_POS = 24'd33;
    localparam logic [23:0] MSG_TIMESYNC   = 24'd111;

    // Input word: one frame byte
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
        logic       tags_valid;
    } t_in_word;

    // Output word: one decoded frame
    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  kind;
        logic [7:0]  sender_sys;
        logic [7:0]  sender_comp;
        logic        healthy;
        logic        extra_present;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [31:0] word_c;
        logic [15:0] ground_speed;
        logic [15:0] heading;
    } t_out_word;

    // Header and CRC summary of a frame, as it stands after its last byte
    typedef struct packed {
        logic        header_error;
        logic        tags_seen;
        logic        too_short;
        logic        len_ok;
        logic [7:0]  sender_sys;
        logic [7:0]  sender_comp;
        logic [23:0] message_id;
        logic [7:0]  payload_length;
        logic [15:0] running_crc;
        logic [15:0] received_crc;
    } t_frame_sum;

    // Per-message table entry
    typedef struct packed {
        logic       known;
        logic [7:0] crc_extra;
        logic [7:0] need;
        logic [2:0] kind;
    } t_msg_info;

    // X.25 CRC, one byte
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
    endfunction

    // CRC extra byte, minimum payload and kind per message id
    function automatic t_msg_info msg_lookup(input logic [23:0] id);
        t_msg_info info;
        info = '0;
        case (id)
            MSG_HEARTBEAT: begin
                info = '{known: 1'b1, crc_extra: 8'd50, need: 8'd9, kind: KIND_HEARTBEAT};
            end
            MSG_SYS_STATUS: begin
                info = '{known: 1'b1, crc_extra: 8'd124, need: 8'd31, kind: KIND_SYS_STATUS};
            end
            MSG_ATTITUDE: begin
                info = '{known: 1'b1, crc_extra: 8'd39, need: 8'd16, kind: KIND_ATTITUDE};
            end
            MSG_GLOBAL_POS: begin
                info = '{known: 1'b1, crc_extra: 8'd104, need: 8'd28, kind: KIND_GLOBAL_POS};
            end
            MSG_TIMESYNC: begin
                info = '{known: 1'b1, crc_extra: 8'd34, need: 8'd16, kind: KIND_TIMESYNC};
            end
            default: begin
                info = '0;
            end
        endcase
        return info;
    endfunction

endpackage

// ===== design/mvd_capture_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvd_capture_ram
// Payload capture store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mvd_capture_ram (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [mvd_pkg::CAP_AW-1:0] i_wr_addr,
    input  logic [7:0]                i_wr_data,
    input  logic                      i_rd_en,
    input  logic [mvd_pkg::CAP_AW-1:0] i_rd_addr,
    output logic [7:0]                o_rd_data
);
    import mvd_pkg::*;

    logic [7:0] r_mem [CAPTURE_BYTES];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== design/mvd_byte_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvd_byte_parser
// Per-byte frame tracking: header fields, running CRC, received CRC and the
// write of payload bytes into the capture store.
// ----------------------------------------------------------------------------
module mvd_byte_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_take,
    input  mvd_pkg::t_in_word          i_word,
    output mvd_pkg::t_frame_sum        o_sum,
    output logic                       o_cap_wr_en,
    output logic [mvd_pkg::CAP_AW-1:0] o_cap_wr_addr,
    output logic [7:0]                 o_cap_wr_data
);
    import mvd_pkg::*;

    logic [8:0]  r_index;
    logic [7:0]  r_plen;
    logic [15:0] r_crc;
    logic [15:0] r_rcrc;
    logic [7:0]  r_sys;
    logic [7:0]  r_comp;
    logic [23:0] r_msgid;
    logic        r_herr;
    logic        r_tags;

    logic [7:0]  n_plen;
    logic [15:0] n_crc;
    logic [15:0] n_rcrc;
    logic [7:0]  n_sys;
    logic [7:0]  n_comp;
    logic [23:0] n_msgid;
    logic        n_herr;
    logic        n_tags;
    logic        cap_hit;
    logic [8:0]  cap_off;
    logic [9:0]  crc_last;
    logic [9:0]  index_w;
    logic [7:0]  b;

    assign b       = i_word.frame_byte;
    assign index_w = {1'b0, r_index};
    assign cap_off = r_index - PAYLOAD_START;

    // Next frame state for the byte on the input
    always_comb begin
        n_plen   = r_plen;
        n_crc    = r_crc;
        n_rcrc   = r_rcrc;
        n_sys    = r_sys;
        n_comp   = r_comp;
        n_msgid  = r_msgid;
        n_herr   = r_herr;
        n_tags   = r_tags;
        cap_hit  = 1'b0;
        crc_last = '0;
        if (r_index == '0) begin
            n_tags = i_word.tags_valid;
            n_herr = (b != START_BYTE);
            n_crc  = CRC_INIT;
        end else begin
            case (r_index)
                9'd1:    n_plen = b;
                9'd5:    n_sys  = b;
                9'd6:    n_comp = b;
                9'd7:    n_msgid = {16'h0000, b};
                9'd8:    n_msgid[15:8] = b;
                9'd9:    n_msgid[23:16] = b;
                default: ;
            endcase
            // CRC covers bytes 1 up to the end of the payload
            crc_last = 10'd9 + {2'b00, n_plen};
            if (index_w <= crc_last) begin
                n_crc   = crc_step(r_crc, b);
                cap_hit = (r_index >= PAYLOAD_START) && (cap_off < 9'(CAPTURE_BYTES));
            end else if (index_w == crc_last + 10'd1) begin
                n_rcrc = {8'h00, b};
            end else if (index_w == crc_last + 10'd2) begin
                n_rcrc = r_rcrc | {b, 8'h00};
            end
        end
    end

    // Summary as it stands once this byte is taken
    always_comb begin
        o_sum.header_error   = n_herr;
        o_sum.tags_seen      = n_tags;
        o_sum.too_short      = (r_index < 9'd11);
        o_sum.len_ok         = (index_w == 10'd11 + {2'b00, n_plen});
        o_sum.sender_sys     = n_sys;
        o_sum.sender_comp    = n_comp;
        o_sum.message_id     = n_msgid;
        o_sum.payload_length = n_plen;
        o_sum.running_crc    = n_crc;
        o_sum.received_crc   = n_rcrc;
    end

    assign o_cap_wr_en   = i_take && cap_hit;
    assign o_cap_wr_addr = cap_off[CAP_AW-1:0];
    assign o_cap_wr_data = b;

    // Frame state; cleared on reset and after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_word.frame_end)) begin
            r_index <= '0;
            r_plen  <= '0;
            r_crc   <= CRC_INIT;
            r_rcrc  <= '0;
            r_sys   <= '0;
            r_comp  <= '0;
            r_msgid <= '0;
            r_herr  <= 1'b0;
            r_tags  <= 1'b0;
        end else if (i_take) begin
            r_plen  <= n_plen;
            r_crc   <= n_crc;
            r_rcrc  <= n_rcrc;
            r_sys   <= n_sys;
            r_comp  <= n_comp;
            r_msgid <= n_msgid;
            r_herr  <= n_herr;
            r_tags  <= n_tags;
            if (r_index != INDEX_MAX) begin
                r_index <= r_index + 9'd1;
            end
        end
    end

endmodule

// ===== design/mvd_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvd_isqrt
// Integer square root of a 32-bit value, two radicand bits per cycle.
// o_done is registered and pulses in the cycle after the last step.
// ----------------------------------------------------------------------------
module mvd_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_value,
    output logic        o_done,
    output logic [15:0] o_root
);
    import mvd_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [31:0] r_v;
    logic [31:0] r_res;

    logic [31:0] bit_w;
    logic [31:0] trial;
    logic [32:0] diff;

    // One restoring step: trial = res + bit
    assign bit_w = 32'h0000_0001 << {4'd15 - r_cnt, 1'b0};
    assign trial = r_res + bit_w;
    assign diff  = {1'b0, r_v} - {1'b0, trial};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_v    <= i_value;
                r_res  <= '0;
            end else if (r_busy) begin
                if (!diff[32]) begin
                    r_v   <= diff[31:0];
                    r_res <= (r_res >> 1) + bit_w;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[15:0];

endmodule

// ===== design/mavlink_v2_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavlink_v2_frame_decoder_unit
// MAVLink v2 frame decoder: header and CRC checks, payload decode of five
// message types, ground speed by integer square root.
// ----------------------------------------------------------------------------
// Input channel: one frame byte per word, frame_end on the last byte,
// tags_valid sampled on the first byte. Bytes are taken one per cycle while
// a frame is being received.
// Output channel: one result word per frame, after the frame_end byte.
// After frame_end the input stalls while the result is built: S_CHECK runs
// the checks, then S_READ reads the capture memory one byte per cycle on its
// single read port, then S_OUT loads the result. A global position frame adds
// S_ABS and S_MULX (absolute value and squaring) and S_MULY, then waits in
// S_SQRT for the square root unit. A frame that fails a check skips the reads.
// The result sits in an output register; the next frame's bytes are taken
// while it waits for the receiver. A new result waits in the finish stage
// until that register is free.
// Reset clears the frame state and the output valid; the capture memory
// keeps its contents and needs no clearing.
// ----------------------------------------------------------------------------
module mavlink_v2_frame_decoder_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mvd_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mvd_pkg::t_out_word o_out_word
);
    import mvd_pkg::*;

    localparam int         STEP_W    = 5;
    localparam logic [4:0] LAST_STEP = 5'd20;

    // Capture offsets read outside the word and velocity runs
    localparam logic [7:0] OFF_BASE_MODE = 8'd6;
    localparam logic [7:0] OFF_HB_STATE  = 8'd7;
    localparam logic [7:0] OFF_BATTERY   = 8'd30;

    typedef enum logic [2:0] {
        S_RECV,
        S_CHECK,
        S_READ,
        S_ABS,
        S_MULX,
        S_MULY,
        S_SQRT,
        S_OUT
    } t_state;

    // Capture offset for each read step
    function automatic logic [CAP_AW-1:0] read_offset(input logic [STEP_W-1:0] step);
        logic [7:0] off;
        if (step < 5'd12) begin
            off = 8'd4 + 8'(step);
        end else if (step < 5'd16) begin
            off = 8'(step) + 8'd8;
        end else if (step < 5'd18) begin
            off = 8'(step) + 8'd10;
        end else if (step == 5'd18) begin
            off = OFF_BASE_MODE;
        end else if (step == 5'd19) begin
            off = OFF_HB_STATE;
        end else begin
            off = OFF_BATTERY;
        end
        return CAP_AW'(off);
    endfunction

    t_state              r_state;
    t_state              n_state;
    t_frame_sum          r_sum;
    logic [2:0]          r_status;
    logic [2:0]          r_kind;
    logic [STEP_W-1:0]   r_step;
    logic [STEP_W-1:0]   r_rd_step;
    logic                r_rd_valid;
    logic [95:0]         r_wabc;
    logic [31:0]         r_vel;
    logic [15:0]         r_hd;
    logic [7:0]          r_base;
    logic [7:0]          r_hb_state;
    logic [7:0]          r_bat;
    logic [15:0]         r_ax;
    logic [15:0]         r_ay;
    logic [31:0]         r_sqx;
    logic [31:0]         r_sqy;
    logic [15:0]         r_root;
    logic                r_out_valid;
    t_out_word           r_out_word;

    t_frame_sum          sum_next;
    t_msg_info           info;
    logic [2:0]          status_next;
    logic                take;
    logic                cap_wr_en;
    logic [CAP_AW-1:0]   cap_wr_addr;
    logic [7:0]          cap_wr_data;
    logic                rd_en;
    logic [7:0]          rd_data;
    logic                sqrt_start;
    logic                sqrt_done;
    logic [15:0]         sqrt_root;
    logic                out_load;
    t_out_word           out_next;

    assign o_in_ready = (r_state == S_RECV);
    assign take       = i_in_valid && o_in_ready;

    mvd_byte_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_word        (i_in_word),
        .o_sum         (sum_next),
        .o_cap_wr_en   (cap_wr_en),
        .o_cap_wr_addr (cap_wr_addr),
        .o_cap_wr_data (cap_wr_data)
    );

    // Writes happen only in S_RECV and reads only after it: no overlap
    mvd_capture_ram u_capture (
        .i_clk     (i_clk),
        .i_wr_en   (cap_wr_en),
        .i_wr_addr (cap_wr_addr),
        .i_wr_data (cap_wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (read_offset(r_step)),
        .o_rd_data (rd_data)
    );

    assign sqrt_start = (r_state == S_MULY);

    mvd_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (r_sqx + r_sqy),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // Frame checks, lowest code first
    always_comb begin
        info = msg_lookup(r_sum.message_id);
        if (r_sum.too_short || r_sum.header_error) begin
            status_next = ST_BAD_START;
        end else if (!r_sum.tags_seen) begin
            status_next = ST_BAD_TAGS;
        end else if (!r_sum.len_ok) begin
            status_next = ST_LENGTH;
        end else if (r_sum.sender_sys == '0 || r_sum.sender_comp == '0) begin
            status_next = ST_ZERO_ID;
        end else if (!info.known) begin
            status_next = ST_UNKNOWN;
        end else if (crc_step(r_sum.running_crc, info.crc_extra) != r_sum.received_crc) begin
            status_next = ST_CRC;
        end else if (r_sum.payload_length < info.need) begin
            status_next = ST_SHORT;
        end else begin
            status_next = ST_OK;
        end
    end

    assign rd_en    = (r_state == S_READ) && (r_step <= LAST_STEP);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RECV: begin
                if (take && i_in_word.frame_end) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = (status_next == ST_OK) ? S_READ : S_OUT;
            end
            S_READ: begin
                if (r_rd_valid && r_rd_step == LAST_STEP) begin
                    n_state = (r_kind == KIND_GLOBAL_POS) ? S_ABS : S_OUT;
                end
            end
            S_ABS:   n_state = S_MULX;
            S_MULX:  n_state = S_MULY;
            S_MULY:  n_state = S_SQRT;
            S_SQRT: begin
                if (sqrt_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_RECV;
                end
            end
            default: n_state = S_RECV;
        endcase
    end

    // Result word; fields without meaning stay zero
    always_comb begin
        out_next        = '0;
        out_next.status = r_status;
        if (r_status == ST_OK) begin
            out_next.kind        = r_kind;
            out_next.sender_sys  = r_sum.sender_sys;
            out_next.sender_comp = r_sum.sender_comp;
            case (r_kind)
                KIND_HEARTBEAT: begin
                    out_next.healthy = (r_hb_state != '0);
                    out_next.word_a  = {24'h000000, r_base};
                end
                KIND_SYS_STATUS: begin
                    out_next.healthy = 1'b1;
                    if (!r_bat[7]) begin
                        out_next.extra_present = 1'b1;
                        out_next.word_a        = {24'h000000, r_bat};
                    end
                end
                KIND_ATTITUDE: begin
                    out_next.word_a = r_wabc[31:0];
                    out_next.word_b = r_wabc[63:32];
                    out_next.word_c = r_wabc[95:64];
                end
                KIND_GLOBAL_POS: begin
                    out_next.word_a       = r_wabc[31:0];
                    out_next.word_b       = r_wabc[63:32];
                    out_next.word_c       = r_wabc[95:64];
                    out_next.ground_speed = r_root;
                    if (r_hd != 16'hFFFF) begin
                        out_next.extra_present = 1'b1;
                        out_next.heading       = r_hd;
                    end
                end
                default: ;
            endcase
        end
    end

    // State, datapath and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RECV;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_en;
            r_rd_step  <= r_step;

            if (take && i_in_word.frame_end) begin
                r_sum <= sum_next;
            end

            if (r_state == S_CHECK) begin
                r_status <= status_next;
                r_kind   <= info.kind;
                r_step   <= '0;
            end else if (rd_en) begin
                r_step <= r_step + 5'd1;
            end

            // Place each returned capture byte
            if (r_rd_valid) begin
                if (r_rd_step < 5'd12) begin
                    r_wabc[{r_rd_step[3:0], 3'b000} +: 8] <= rd_data;
                end else if (r_rd_step < 5'd16) begin
                    r_vel[{r_rd_step[1:0], 3'b000} +: 8] <= rd_data;
                end else if (r_rd_step < 5'd18) begin
                    r_hd[{r_rd_step[0], 3'b000} +: 8] <= rd_data;
                end else if (r_rd_step == 5'd18) begin
                    r_base <= rd_data;
                end else if (r_rd_step == 5'd19) begin
                    r_hb_state <= rd_data;
                end else begin
                    r_bat <= rd_data;
                end
            end

            // Ground speed operands; both squares ready when the root starts
            if (r_state == S_ABS) begin
                r_ax <= r_vel[15] ? 16'(17'h10000 - {1'b0, r_vel[15:0]}) : r_vel[15:0];
                r_ay <= r_vel[31] ? 16'(17'h10000 - {1'b0, r_vel[31:16]}) : r_vel[31:16];
            end
            if (r_state == S_MULX) begin
                r_sqx <= {16'h0000, r_ax} * {16'h0000, r_ax};
                r_sqy <= {16'h0000, r_ay} * {16'h0000, r_ay};
            end
            if (r_state == S_SQRT && sqrt_done) begin
                r_root <= sqrt_root;
            end

            // Output register
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_word  <= out_next;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== design/mvd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvd_checker
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module mvd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input mvd_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input mvd_pkg::t_out_word o_out_word
);
    import mvd_pkg::*;

    // The last byte of a frame stalls the input while the result is built
    a_end_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in_word.frame_end |=> !o_in_ready)
        else $error("input not stalled after frame end");

    // A good frame always carries nonzero sender ids
    a_ok_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status == ST_OK |->
            o_out_word.sender_sys != '0 && o_out_word.sender_comp != '0)
        else $error("good frame with zero sender id");

    // A failed frame carries the status only
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status != ST_OK |->
            o_out_word.kind == '0 && o_out_word.sender_sys == '0 &&
            o_out_word.sender_comp == '0 && o_out_word.healthy == 1'b0 &&
            o_out_word.extra_present == 1'b0 && o_out_word.word_a == '0 &&
            o_out_word.word_b == '0 && o_out_word.word_c == '0 &&
            o_out_word.ground_speed == '0 && o_out_word.heading == '0)
        else $error("failed frame with nonzero fields");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result changed while stalled");

endmodule

bind mavlink_v2_frame_decoder_unit mvd_checker u_mvd_checker (.*);

// ===== tb/tb_mavlink_v2_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mavlink_v2_frame_decoder_unit
// Self-checking bench for the MAVLink v2 frame decoder. Frames are pushed in
// one byte per word: hand-built corner frames first, then random traffic that
// is mostly well-formed frames with some broken frames and noise mixed in.
// A scoreboard decodes every accepted frame on its own and checks each result
// word in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_mavlink_v2_frame_decoder_unit;
    import mvd_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int DRAIN_WAIT  = 80;
    localparam int RUN_LIMIT   = 10_000_000;
    localparam int RAND_BYTES  = 1400;
    localparam int RAND_FRAMES = 30;

    // ------------------------------------------------------------------------
    // Scoreboard: decodes the byte stream and keeps the results still owed
    // ------------------------------------------------------------------------
    class frame_scoreboard;
        t_out_word  pending_decodes[$];
        int         errors;

        // frame being received
        bit [8:0]   idx;
        bit [7:0]   plen;
        bit [15:0]  crc;
        bit [15:0]  rx_crc;
        bit [7:0]   sys_id;
        bit [7:0]   comp_id;
        bit [23:0]  msg;
        bit         hdr_bad;
        bit         tags_ok;
        bit [7:0]   capture[CAPTURE_BYTES];

        function new();
            errors = 0;
            foreach (capture[k]) capture[k] = 8'h00;
            clear_frame();
        endfunction

        // X.25 CRC over one byte
        static function bit [15:0] x25_update(bit [15:0] acc, bit [7:0] b);
            bit [7:0]  t;
            bit [15:0] tt;
            t  = b ^ acc[7:0];
            t  = t ^ (t << 4);
            tt = {8'h00, t};
            return (acc >> 8) ^ (tt << 8) ^ (tt << 3) ^ (tt >> 4);
        endfunction

        // CRC extra, minimum payload and kind of the supported messages
        static function void msg_table(input bit [23:0] id, output bit known,
                                       output bit [7:0] extra, output bit [7:0] need,
                                       output bit [2:0] kind);
            known = 1'b1;
            extra = 8'd0;
            need  = 8'd0;
            kind  = KIND_HEARTBEAT;
            case (id)
                MSG_HEARTBEAT: begin
                    extra = 8'd50;  need = 8'd9;  kind = KIND_HEARTBEAT;
                end
                MSG_SYS_STATUS: begin
                    extra = 8'd124; need = 8'd31; kind = KIND_SYS_STATUS;
                end
                MSG_ATTITUDE: begin
                    extra = 8'd39;  need = 8'd16; kind = KIND_ATTITUDE;
                end
                MSG_GLOBAL_POS: begin
                    extra = 8'd104; need = 8'd28; kind = KIND_GLOBAL_POS;
                end
                MSG_TIMESYNC: begin
                    extra = 8'd34;  need = 8'd16; kind = KIND_TIMESYNC;
                end
                default: begin
                    known = 1'b0;
                end
            endcase
        endfunction

        // floor of the square root, bit by bit
        static function bit [15:0] int_sqrt(bit [31:0] v);
            bit [31:0] rem;
            bit [31:0] root;
            bit [31:0] b;
            rem  = v;
            root = 0;
            b    = 32'h4000_0000;
            while (b > rem) b >>= 2;
            while (b != 0) begin
                if (rem >= root + b) begin
                    rem  = rem - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
                b >>= 2;
            end
            return root[15:0];
        endfunction

        function void clear_frame();
            idx     = 0;
            plen    = 0;
            crc     = CRC_INIT;
            rx_crc  = 0;
            sys_id  = 0;
            comp_id = 0;
            msg     = 0;
            hdr_bad = 0;
            tags_ok = 0;
        endfunction

        // little-endian 32-bit word from the capture
        function bit [31:0] cap_word(int off);
            return {capture[off + 3], capture[off + 2], capture[off + 1], capture[off]};
        endfunction

        // result of the frame that has just ended
        function t_out_word decode_frame();
            t_out_word r;
            int        frame_size;
            bit        known;
            bit [7:0]  extra;
            bit [7:0]  need;
            bit [2:0]  kind;
            bit [2:0]  st;
            bit [15:0] vx;
            bit [15:0] vy;
            bit [15:0] hd;
            bit [31:0] ax;
            bit [31:0] ay;
            r          = '0;
            frame_size = int'(idx) + 1;
            msg_table(msg, known, extra, need, kind);
            if (frame_size < 12 || hdr_bad) st = ST_BAD_START;
            else if (!tags_ok) st = ST_BAD_TAGS;
            else if (frame_size != 12 + int'(plen)) st = ST_LENGTH;
            else if (sys_id == 0 || comp_id == 0) st = ST_ZERO_ID;
            else if (!known) st = ST_UNKNOWN;
            else if (x25_update(crc, extra) != rx_crc) st = ST_CRC;
            else if (plen < need) st = ST_SHORT;
            else st = ST_OK;
            r.status = st;
            if (st != ST_OK) return r;

            r.kind        = kind;
            r.sender_sys  = sys_id;
            r.sender_comp = comp_id;
            case (kind)
                KIND_HEARTBEAT: begin
                    r.healthy = (capture[7] != 0);
                    r.word_a  = {24'h0, capture[6]};
                end
                KIND_SYS_STATUS: begin
                    r.healthy = 1'b1;
                    // negative battery percent means no reading
                    if (!capture[30][7]) begin
                        r.extra_present = 1'b1;
                        r.word_a        = {24'h0, capture[30]};
                    end
                end
                KIND_ATTITUDE, KIND_GLOBAL_POS: begin
                    r.word_a = cap_word(4);
                    r.word_b = cap_word(8);
                    r.word_c = cap_word(12);
                    if (kind == KIND_GLOBAL_POS) begin
                        vx = {capture[21], capture[20]};
                        vy = {capture[23], capture[22]};
                        hd = {capture[27], capture[26]};
                        ax = vx[15] ? 32'h1_0000 - vx : {16'h0, vx};
                        ay = vy[15] ? 32'h1_0000 - vy : {16'h0, vy};
                        r.ground_speed = int_sqrt(ax * ax + ay * ay);
                        if (hd != 16'hFFFF) begin
                            r.extra_present = 1'b1;
                            r.heading       = hd;
                        end
                    end
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        // absorb one accepted input word
        function void note_word(t_in_word w);
            int       i;
            bit [7:0] b;
            i = idx;
            b = w.frame_byte;
            if (i == 0) begin
                tags_ok = w.tags_valid;
                hdr_bad = (b != START_BYTE);
                crc     = CRC_INIT;
            end else begin
                case (i)
                    1: plen    = b;
                    5: sys_id  = b;
                    6: comp_id = b;
                    7: msg     = {16'h0, b};
                    8: msg[15:8]  = b;
                    9: msg[23:16] = b;
                    default: ;
                endcase
                if (i <= 9 + int'(plen)) begin
                    crc = x25_update(crc, b);
                    if (i >= 10 && i - 10 < CAPTURE_BYTES) capture[i - 10] = b;
                end else if (i == 10 + int'(plen)) begin
                    rx_crc = {8'h00, b};
                end else if (i == 11 + int'(plen)) begin
                    rx_crc[15:8] = b;
                end
            end
            if (w.frame_end) begin
                pending_decodes.push_back(decode_frame());
                clear_frame();
            end else if (idx != INDEX_MAX) begin
                idx++;
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, seen);
            end
        endfunction

        // check one result word against the oldest owed result
        function void check_decode(t_out_word got);
            t_out_word want;
            if (pending_decodes.size() == 0) begin
                errors++;
                $display("%0t: result word with none owed, actual %0h", $time, got);
                return;
            end
            want = pending_decodes.pop_front();
            compare_field("status",        want.status,        got.status);
            compare_field("kind",          want.kind,          got.kind);
            compare_field("sender_sys",    want.sender_sys,    got.sender_sys);
            compare_field("sender_comp",   want.sender_comp,   got.sender_comp);
            compare_field("healthy",       want.healthy,       got.healthy);
            compare_field("extra_present", want.extra_present, got.extra_present);
            compare_field("word_a",        want.word_a,        got.word_a);
            compare_field("word_b",        want.word_b,        got.word_b);
            compare_field("word_c",        want.word_c,        got.word_c);
            compare_field("ground_speed",  want.ground_speed,  got.ground_speed);
            compare_field("heading",       want.heading,       got.heading);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------------
    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_word o_out_word;

    frame_scoreboard decodes;
    int feed_calm;
    int sink_calm;
    int bytes_sent;
    int frames_sent;

    mavlink_v2_frame_decoder_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------

    // idle cycles before a word, with runs of back-to-back words
    function automatic int draw_gap(ref int calm_left);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 10);
    endfunction

    function automatic void rand_payload(ref bit [7:0] p[$], input int len);
        p.delete();
        repeat (len) p.push_back(8'($urandom_range(0, 255)));
    endfunction

    // header, payload and a correct CRC
    function automatic void seal_frame(ref bit [7:0] f[$], input bit [23:0] id,
                                       input bit [7:0] sys_id, input bit [7:0] comp_id,
                                       ref bit [7:0] pay[$]);
        bit [15:0] crc;
        bit        known;
        bit [7:0]  extra;
        bit [7:0]  need;
        bit [2:0]  kind;
        f.delete();
        f.push_back(START_BYTE);
        f.push_back(8'(pay.size()));
        repeat (3) f.push_back(8'($urandom_range(0, 255)));
        f.push_back(sys_id);
        f.push_back(comp_id);
        f.push_back(id[7:0]);
        f.push_back(id[15:8]);
        f.push_back(id[23:16]);
        foreach (pay[k]) f.push_back(pay[k]);
        crc = CRC_INIT;
        for (int k = 1; k < f.size(); k++) crc = frame_scoreboard::x25_update(crc, f[k]);
        frame_scoreboard::msg_table(id, known, extra, need, kind);
        crc = frame_scoreboard::x25_update(crc, extra);
        f.push_back(crc[7:0]);
        f.push_back(crc[15:8]);
    endfunction

    // one word on the input channel; entered and left at a falling edge
    task automatic send_word(input t_in_word w);
        int gap;
        gap = draw_gap(feed_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        decodes.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input bit [7:0] f[$], input bit tags);
        t_in_word w;
        foreach (f[k]) begin
            w.frame_byte = f[k];
            w.frame_end  = (k == f.size() - 1);
            w.tags_valid = (k == 0) ? tags : 1'($urandom_range(0, 1));
            send_word(w);
        end
        bytes_sent += f.size();
        frames_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Directed frames: field extremes, each kind, each error
    // ------------------------------------------------------------------------
    task automatic directed_frames();
        bit [7:0] f[$];
        bit [7:0] pay[$];

        // heartbeat not healthy, all-ones ids and base mode
        rand_payload(pay, 9);
        pay[6] = 8'hFF;
        pay[7] = 8'h00;
        seal_frame(f, MSG_HEARTBEAT, 8'hFF, 8'hFF, pay);
        send_frame(f, 1'b1);

        // heartbeat healthy, smallest ids
        rand_payload(pay, 9);
        pay[6] = 8'h00;
        pay[7] = 8'h80;
        seal_frame(f, MSG_HEARTBEAT, 8'h01, 8'h01, pay);
        send_frame(f, 1'b1);

        // sys status, battery at top of range and negative
        rand_payload(pay, 31);
        pay[30] = 8'h7F;
        seal_frame(f, MSG_SYS_STATUS, 8'h12, 8'h34, pay);
        send_frame(f, 1'b1);
        rand_payload(pay, 31);
        pay[30] = 8'h80;
        seal_frame(f, MSG_SYS_STATUS, 8'h56, 8'h78, pay);
        send_frame(f, 1'b1);

        // sys status longer than the capture
        rand_payload(pay, 40);
        pay[30] = 8'h00;
        seal_frame(f, MSG_SYS_STATUS, 8'h9A, 8'hBC, pay);
        send_frame(f, 1'b1);

        // attitude
        rand_payload(pay, 16);
        seal_frame(f, MSG_ATTITUDE, 8'hA5, 8'h5A, pay);
        send_frame(f, 1'b1);

        // global position: most negative speeds, heading absent
        rand_payload(pay, 28);
        pay[20] = 8'h00; pay[21] = 8'h80;
        pay[22] = 8'h00; pay[23] = 8'h80;
        pay[26] = 8'hFF; pay[27] = 8'hFF;
        seal_frame(f, MSG_GLOBAL_POS, 8'h01, 8'hFF, pay);
        send_frame(f, 1'b1);

        // global position: most positive speeds, largest heading
        rand_payload(pay, 28);
        pay[20] = 8'hFF; pay[21] = 8'h7F;
        pay[22] = 8'hFF; pay[23] = 8'h7F;
        pay[26] = 8'hFE; pay[27] = 8'hFF;
        seal_frame(f, MSG_GLOBAL_POS, 8'hFF, 8'h01, pay);
        send_frame(f, 1'b1);

        // global position: standing still, heading zero
        rand_payload(pay, 28);
        pay[20] = 8'h00; pay[21] = 8'h00;
        pay[22] = 8'h00; pay[23] = 8'h00;
        pay[26] = 8'h00; pay[27] = 8'h00;
        seal_frame(f, MSG_GLOBAL_POS, 8'h33, 8'h44, pay);
        send_frame(f, 1'b1);

        // timesync
        rand_payload(pay, 16);
        seal_frame(f, MSG_TIMESYNC, 8'h10, 8'h20, pay);
        send_frame(f, 1'b1);

        // single byte frame, then an 11 byte frame
        f.delete();
        f.push_back(START_BYTE);
        send_frame(f, 1'b1);
        rand_payload(pay, 9);
        seal_frame(f, MSG_HEARTBEAT, 8'h01, 8'h01, pay);
        f = f[0:10];
        send_frame(f, 1'b1);

        // bad start byte
        rand_payload(pay, 9);
        seal_frame(f, MSG_HEARTBEAT, 8'h01, 8'h02, pay);
        f[0] = 8'h00;
        send_frame(f, 1'b1);

        // bad tags
        rand_payload(pay, 16);
        seal_frame(f, MSG_TIMESYNC, 8'h01, 8'h02, pay);
        send_frame(f, 1'b0);

        // one byte too many
        rand_payload(pay, 16);
        seal_frame(f, MSG_ATTITUDE, 8'h01, 8'h02, pay);
        f.push_back(8'hFF);
        send_frame(f, 1'b1);

        // zero system id, then zero component id
        rand_payload(pay, 9);
        seal_frame(f, MSG_HEARTBEAT, 8'h00, 8'h02, pay);
        send_frame(f, 1'b1);
        rand_payload(pay, 9);
        seal_frame(f, MSG_HEARTBEAT, 8'h02, 8'h00, pay);
        send_frame(f, 1'b1);

        // unknown message id
        rand_payload(pay, 20);
        seal_frame(f, 24'hFFFFFF, 8'h01, 8'h02, pay);
        send_frame(f, 1'b1);

        // CRC error
        rand_payload(pay, 16);
        seal_frame(f, MSG_TIMESYNC, 8'h01, 8'h02, pay);
        f[f.size() - 1] ^= 8'h01;
        send_frame(f, 1'b1);

        // payload one byte short, and empty payload
        rand_payload(pay, 8);
        seal_frame(f, MSG_HEARTBEAT, 8'h01, 8'h02, pay);
        send_frame(f, 1'b1);
        rand_payload(pay, 0);
        seal_frame(f, MSG_GLOBAL_POS, 8'h01, 8'h02, pay);
        send_frame(f, 1'b1);

        // overlong frame: index saturates
        f.delete();
        f.push_back(START_BYTE);
        repeat (519) f.push_back(8'($urandom_range(0, 255)));
        send_frame(f, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Random frame: mostly good, some broken, some noise
    // ------------------------------------------------------------------------
    task automatic send_random_frame();
        bit [7:0]  f[$];
        bit [7:0]  pay[$];
        bit [23:0] id;
        bit [7:0]  sys_id;
        bit [7:0]  comp_id;
        bit        tags;
        bit        known;
        bit [7:0]  extra;
        bit [7:0]  need;
        bit [2:0]  kind;
        bit [15:0] spd;
        int        len;
        int        pick;
        int        cut;

        case ($urandom_range(0, 4))
            0: id = MSG_HEARTBEAT;
            1: id = MSG_SYS_STATUS;
            2: id = MSG_ATTITUDE;
            3: id = MSG_GLOBAL_POS;
            default: id = MSG_TIMESYNC;
        endcase
        frame_scoreboard::msg_table(id, known, extra, need, kind);
        if ($urandom_range(0, 9) == 0) len = need + $urandom_range(0, 255 - need);
        else len = need + $urandom_range(0, 6);
        sys_id  = 8'($urandom_range(1, 255));
        comp_id = 8'($urandom_range(1, 255));
        tags    = 1'b1;
        pick    = $urandom_range(0, 99);

        // faults that must go in before the CRC
        if (pick >= 86 && pick <= 87) begin
            if ($urandom_range(0, 1)) sys_id = 8'h00;
            else comp_id = 8'h00;
        end else if (pick >= 88 && pick <= 90) begin
            id = 24'($urandom_range(0, 24'hFFFFFF));
        end else if (pick >= 94 && pick <= 96) begin
            len = $urandom_range(0, need - 1);
        end

        rand_payload(pay, len);
        if (id == MSG_HEARTBEAT && len > 7 && $urandom_range(0, 2) == 0) pay[7] = 8'h00;
        if (id == MSG_GLOBAL_POS && len >= 28) begin
            if ($urandom_range(0, 2) == 0) begin
                pay[26] = 8'hFF;
                pay[27] = 8'hFF;
            end
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: spd = 16'h8000;
                    1: spd = 16'h7FFF;
                    2: spd = 16'hFFFF;
                    default: spd = 16'h0000;
                endcase
                pay[20] = spd[7:0];
                pay[21] = spd[15:8];
                pay[22] = spd[7:0] ^ 8'($urandom_range(0, 1));
                pay[23] = spd[15:8];
            end
        end
        seal_frame(f, id, sys_id, comp_id, pay);

        // faults on the finished frame
        if (pick >= 75 && pick <= 77) begin
            f[0] = START_BYTE ^ 8'($urandom_range(1, 255));
        end else if (pick >= 78 && pick <= 79) begin
            cut = $urandom_range(1, 11);
            f   = f[0:cut - 1];
        end else if (pick >= 80 && pick <= 82) begin
            tags = 1'b0;
        end else if (pick >= 83 && pick <= 85) begin
            if ($urandom_range(0, 1)) begin
                repeat ($urandom_range(1, 3)) f.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 3)) void'(f.pop_back());
            end
        end else if (pick >= 91 && pick <= 93) begin
            f[f.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
        end else if (pick >= 97) begin
            f.delete();
            repeat ($urandom_range(1, 40)) f.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) f[0] = START_BYTE;
            tags = 1'($urandom_range(0, 1));
        end
        send_frame(f, tags);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, every word checked
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = draw_gap(sink_calm);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            decodes.check_decode(o_out_word);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        decodes     = new();
        feed_calm   = 0;
        sink_calm   = 0;
        bytes_sent  = 0;
        frames_sent = 0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // totals count the directed frames too
        directed_frames();
        while (bytes_sent < RAND_BYTES || frames_sent < RAND_FRAMES) send_random_frame();
        i_in_valid <= 1'b0;

        // drain owed results, then watch for strays
        while (decodes.pending_decodes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (decodes.errors == 0) begin
            $display("tb_mavlink_v2_frame_decoder_unit passed");
        end else begin
            $display("tb_mavlink_v2_frame_decoder_unit failed");
        end
        $finish;
    end

    // hang guard
    initial begin : watchdog
        #(RUN_LIMIT);
        $display("tb_mavlink_v2_frame_decoder_unit failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mvd_pkg.sv
design/mvd_capture_ram.sv
design/mvd_byte_parser.sv
design/mvd_isqrt.sv
design/mavlink_v2_frame_decoder_unit.sv
design/mvd_checker.sv
tb/tb_mavlink_v2_frame_decoder_unit.sv
